### sv/msc_pkg.sv
// Shared types, field widths and codes of the motion sequence controller.
`timescale 1ns / 1ps

package msc_pkg;

   localparam int unsigned OpW      = 2;
   localparam int unsigned SeqIdW   = 4;
   localparam int unsigned CountW   = 8;
   localparam int unsigned ParamW   = 16;
   localparam int unsigned TimeW    = 32;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned CsrAddrW = 3;

   localparam int unsigned NumSequencesDefault = 16;
   localparam int unsigned MaxMotionsDefault   = 256;

   localparam logic [ParamW-1:0] ResetSpeed   = 16'd100;
   localparam logic [TimeW-1:0]  ResetTimeout = 32'd20000;
   localparam logic [ParamW-1:0] PushPullCurv = 16'd10;
   localparam logic [ParamW-1:0] PushPullDist = 16'd100;

   localparam logic [SeqIdW-1:0] SeqNone     = 4'd0;
   localparam logic [SeqIdW-1:0] SeqUp       = 4'd1;
   localparam logic [SeqIdW-1:0] SeqDown     = 4'd2;
   localparam logic [SeqIdW-1:0] SeqMove     = 4'd3;
   localparam logic [SeqIdW-1:0] SeqUpDown   = 4'd4;
   localparam logic [SeqIdW-1:0] SeqPushPull = 4'd5;
   localparam logic [SeqIdW-1:0] SeqLast     = 4'd10;

   typedef enum logic [OpW-1:0] {
      OP_POLL,
      OP_SELECT,
      OP_LOAD,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_MOVE,
      PH_WAIT,
      PH_NEXT,
      PH_CHANGE
   } phase_type;

   typedef enum logic [1:0] {
      ST_PREPARE,
      ST_MAIN,
      ST_FINALIZE
   } stage_type;

   typedef enum logic [0:0] {
      REG_DEFAULT_SPEED,
      REG_IDLE_TIMEOUT
   } reg_idx_type;

   typedef struct packed {
      logic [CountW-1:0] main_begin;
      logic [CountW-1:0] final_begin;
      logic [CountW-1:0] total;
      logic              looped;
   } seq_row_type;

   typedef struct packed {
      logic              we;
      logic [SeqIdW-1:0] idx;
      seq_row_type       row;
   } tbl_wr_type;

   typedef struct packed {
      logic [ParamW-1:0] default_speed;
      logic [TimeW-1:0]  idle_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [OpW-1:0]           opcode;
      logic [SeqIdW-1:0]        sequence_id;
      logic signed [ParamW-1:0] req_speed;
      logic signed [ParamW-1:0] req_curvature;
      logic signed [ParamW-1:0] req_distance;
      logic                     motion_done;
      logic [TimeW-1:0]         time_ms;
      seq_row_type              row;
   } req_item_type;

   typedef struct packed {
      logic                     start_motion;
      logic [SeqIdW-1:0]        active_sequence;
      logic [CountW-1:0]        motion_index;
      logic                     config_init;
      logic                     config_update;
      logic signed [ParamW-1:0] out_speed;
      logic signed [ParamW-1:0] out_curvature;
      logic signed [ParamW-1:0] out_distance;
      logic                     body_up;
      logic                     fatal_error;
   } rsp_item_type;

endpackage

### sv/msc_req_if.sv
// Request channel of the motion sequence controller.
`timescale 1ns / 1ps

interface msc_req_if;
   import msc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OpW-1:0]           opcode;
   logic [SeqIdW-1:0]        sequence_id;
   logic signed [ParamW-1:0] req_speed;
   logic signed [ParamW-1:0] req_curvature;
   logic signed [ParamW-1:0] req_distance;
   logic                     motion_done;
   logic [TimeW-1:0]         time_ms;
   logic [CountW-1:0]        row_main_begin;
   logic [CountW-1:0]        row_final_begin;
   logic [CountW-1:0]        row_total;
   logic                     row_looped;

   modport source (
      output valid, opcode, sequence_id, req_speed, req_curvature, req_distance,
             motion_done, time_ms, row_main_begin, row_final_begin, row_total,
             row_looped,
      input  ready
   );

   modport sink (
      input  valid, opcode, sequence_id, req_speed, req_curvature, req_distance,
             motion_done, time_ms, row_main_begin, row_final_begin, row_total,
             row_looped,
      output ready
   );
endinterface

### sv/msc_rsp_if.sv
// Result channel of the motion sequence controller.
`timescale 1ns / 1ps

interface msc_rsp_if;
   import msc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     start_motion;
   logic [SeqIdW-1:0]        active_sequence;
   logic [CountW-1:0]        motion_index;
   logic                     config_init;
   logic                     config_update;
   logic signed [ParamW-1:0] out_speed;
   logic signed [ParamW-1:0] out_curvature;
   logic signed [ParamW-1:0] out_distance;
   logic                     body_up;
   logic                     fatal_error;

   modport source (
      output valid, start_motion, active_sequence, motion_index, config_init,
             config_update, out_speed, out_curvature, out_distance, body_up,
             fatal_error,
      input  ready
   );

   modport sink (
      input  valid, start_motion, active_sequence, motion_index, config_init,
             config_update, out_speed, out_curvature, out_distance, body_up,
             fatal_error,
      output ready
   );
endinterface

### sv/msc_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module msc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [msc_pkg::CsrAddrW-1:0]     paddr,
   input  logic [msc_pkg::CsrDataW-1:0]     pwdata,
   output logic [msc_pkg::CsrDataW-1:0]     prdata,
   output logic                             pready,
   output msc_pkg::cfg_type                 cfg
);
   import msc_pkg::*;

   logic [ParamW-1:0] speed_ff;
   logic [ParamW-1:0] speed_in;
   logic [TimeW-1:0]  timeout_ff;
   logic [TimeW-1:0]  timeout_in;
   logic              wr_en;
   reg_idx_type       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = reg_idx_type'(paddr[CsrAddrW-1:2]);

   always_comb begin
      speed_in   = speed_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEFAULT_SPEED: speed_in   = pwdata[ParamW-1:0];
            REG_IDLE_TIMEOUT:  timeout_in = pwdata[TimeW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DEFAULT_SPEED: prdata = CsrDataW'(speed_ff);
         REG_IDLE_TIMEOUT:  prdata = CsrDataW'(timeout_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= ResetSpeed;
         timeout_ff <= ResetTimeout;
      end else begin
         speed_ff   <= speed_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.default_speed   = speed_ff;
   assign cfg.idle_timeout_ms = timeout_ff;

endmodule

### sv/msc_table.sv
// Sequence table: one row per sequence, written by load items, read by the engine.
`timescale 1ns / 1ps

module msc_table #(
   parameter int unsigned NUM_SEQUENCES = msc_pkg::NumSequencesDefault
) (
   input  logic                           clock,
   input  msc_pkg::tbl_wr_type            tbl_wr,
   input  logic [msc_pkg::SeqIdW-1:0]     rd_idx,
   output msc_pkg::seq_row_type           rd_row
);
   import msc_pkg::*;

   // Ids are four bits wide, so rows beyond sixteen can never be addressed.
   localparam int unsigned Depth = (NUM_SEQUENCES < (2 ** SeqIdW)) ?
                                   NUM_SEQUENCES : (2 ** SeqIdW);
   localparam int unsigned IdxW  = $clog2(Depth);

   seq_row_type rows [Depth];

   always_ff @(posedge clock) begin
      if (tbl_wr.we) begin
         rows[tbl_wr.idx[IdxW-1:0]] <= tbl_wr.row;
      end
   end

   assign rd_row = rows[rd_idx[IdxW-1:0]];

endmodule

### sv/msc_engine.sv
// Sequencing engine: input register, state update and result register.
`timescale 1ns / 1ps

module msc_engine #(
   parameter int unsigned NUM_SEQUENCES = msc_pkg::NumSequencesDefault,
   parameter int unsigned MAX_MOTIONS   = msc_pkg::MaxMotionsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   msc_req_if.sink                      req,
   msc_rsp_if.source                    rsp,
   input  msc_pkg::cfg_type             cfg,
   output msc_pkg::tbl_wr_type          tbl_wr,
   output logic [msc_pkg::SeqIdW-1:0]   tbl_rd_idx,
   input  msc_pkg::seq_row_type         tbl_rd_row
);
   import msc_pkg::*;

   localparam int unsigned CntW   = (MAX_MOTIONS > 1) ? $clog2(MAX_MOTIONS) : 1;
   localparam int unsigned IdCmpW = ($clog2(NUM_SEQUENCES + 1) > SeqIdW) ?
                                    $clog2(NUM_SEQUENCES + 1) : SeqIdW;
   localparam logic [IdCmpW-1:0] NumSeqLim = IdCmpW'(NUM_SEQUENCES);
   localparam logic [CountW:0]   WrapAt    = (CountW + 1)'(MAX_MOTIONS);
   localparam logic [CntW-1:0]   CntMax    = CntW'(MAX_MOTIONS - 1);

   // Input register and result register
   req_item_type item_ff;
   req_item_type item_in;
   logic         item_vld_ff;
   logic         item_vld_in;
   rsp_item_type rsp_data_ff;
   rsp_item_type rsp_data_in;
   logic         rsp_vld_ff;
   logic         rsp_vld_in;
   logic         advance;

   // Engine state
   phase_type         phase_ff;
   phase_type         phase_in;
   stage_type         stage_ff;
   stage_type         stage_in;
   logic [CntW-1:0]   cnt_ff;
   logic [CntW-1:0]   cnt_in;
   logic [SeqIdW-1:0] cur_ff;
   logic [SeqIdW-1:0] cur_in;
   logic [SeqIdW-1:0] pend_ff;
   logic [SeqIdW-1:0] pend_in;
   logic              standing_ff;
   logic              standing_in;
   logic [TimeW-1:0]  last_ff;
   logic [TimeW-1:0]  last_in;
   logic [ParamW-1:0] spd_ff;
   logic [ParamW-1:0] spd_in;
   logic [ParamW-1:0] curv_ff;
   logic [ParamW-1:0] curv_in;
   logic [ParamW-1:0] dist_ff;
   logic [ParamW-1:0] dist_in;
   logic              disabled_ff;
   logic              disabled_in;

   // Decode and selection
   logic              poll_go;
   logic [TimeW-1:0]  elapsed;
   logic              timeout_hit;
   logic              sel_go;
   logic [SeqIdW-1:0] sel_id;
   logic [ParamW-1:0] sel_spd;
   logic [ParamW-1:0] sel_curv;
   logic [ParamW-1:0] sel_dist;
   logic              sel_bad;
   logic              start_p;
   logic              init_p;
   logic              upd_p;
   logic              end_main;
   logic              fin_done;
   logic [CntW-1:0]   wrap_tbl [2 ** CountW];

   // Reduction of a restart index from the table modulo the motion count.
   for (genvar g = 0; g < (2 ** CountW); g++) begin : g_wrap
      localparam int unsigned Wrapped = g % MAX_MOTIONS;
      assign wrap_tbl[g] = CntW'(Wrapped);
   end

   // Handshake: the result register lets the next item in while a result waits.
   assign advance     = item_vld_ff && (!rsp_vld_ff || rsp.ready);
   assign req.ready   = !item_vld_ff || advance;
   assign item_vld_in = (req.valid && req.ready) ? 1'b1 :
                        (advance ? 1'b0 : item_vld_ff);
   assign rsp_vld_in  = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);

   always_comb begin
      item_in.opcode          = req.opcode;
      item_in.sequence_id     = req.sequence_id;
      item_in.req_speed       = req.req_speed;
      item_in.req_curvature   = req.req_curvature;
      item_in.req_distance    = req.req_distance;
      item_in.motion_done     = req.motion_done;
      item_in.time_ms         = req.time_ms;
      item_in.row.main_begin  = req.row_main_begin;
      item_in.row.final_begin = req.row_final_begin;
      item_in.row.total       = req.row_total;
      item_in.row.looped      = req.row_looped;
   end

   assign poll_go     = (item_ff.opcode == OP_POLL) && !disabled_ff;
   assign elapsed     = item_ff.time_ms - last_ff;
   assign timeout_hit = elapsed > cfg.idle_timeout_ms;

   // A select item and the idle timeout share one selection path.
   always_comb begin
      sel_go   = (item_ff.opcode == OP_SELECT) ||
                 (poll_go && (phase_ff == PH_IDLE) && (cur_ff == pend_ff) && timeout_hit);
      sel_id   = SeqDown;
      sel_spd  = '0;
      sel_curv = '0;
      sel_dist = '0;
      if (item_ff.opcode == OP_SELECT) begin
         sel_id   = item_ff.sequence_id;
         sel_spd  = $unsigned(item_ff.req_speed);
         sel_curv = $unsigned(item_ff.req_curvature);
         sel_dist = $unsigned(item_ff.req_distance);
      end
   end

   assign sel_bad = IdCmpW'(sel_id) >= NumSeqLim;

   assign tbl_rd_idx = cur_ff;
   always_comb begin
      tbl_wr.we  = advance && (item_ff.opcode == OP_LOAD) &&
                   (IdCmpW'(item_ff.sequence_id) < NumSeqLim);
      tbl_wr.idx = item_ff.sequence_id;
      tbl_wr.row = item_ff.row;
   end

   // Datapath and pulse outputs of one item.
   always_comb begin : datapath
      logic [CountW:0]   nxt;
      logic [CountW-1:0] row_val;
      logic              from_row;
      stage_type         stg;
      logic [SeqIdW-1:0] pend_sel;

      stage_in    = stage_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      pend_in     = pend_ff;
      standing_in = standing_ff;
      last_in     = last_ff;
      spd_in      = spd_ff;
      curv_in     = curv_ff;
      dist_in     = dist_ff;
      disabled_in = disabled_ff;
      start_p     = 1'b0;
      init_p      = 1'b0;
      upd_p       = 1'b0;
      end_main    = 1'b0;
      fin_done    = 1'b0;
      nxt         = (CountW + 1)'(cnt_ff) + 1'b1;
      row_val     = '0;
      from_row    = 1'b0;
      stg         = stage_ff;
      pend_sel    = pend_ff;

      if (sel_go) begin
         if (sel_bad) begin
            disabled_in = 1'b1;
         end else if (sel_id == SeqNone) begin
            pend_in = SeqNone;
         end else begin
            // While down only up is taken; while standing up is refused.
            if (!standing_ff) begin
               if (sel_id == SeqUp) begin
                  pend_sel = sel_id;
                  spd_in   = cfg.default_speed;
                  curv_in  = '0;
                  dist_in  = '0;
               end
            end else if (sel_id == SeqMove) begin
               pend_sel = sel_id;
               spd_in   = sel_spd;
               curv_in  = sel_curv;
               dist_in  = sel_dist;
            end else if (sel_id == SeqPushPull) begin
               pend_sel = sel_id;
               spd_in   = cfg.default_speed;
               curv_in  = PushPullCurv;
               dist_in  = PushPullDist;
            end else if ((sel_id == SeqDown) || (sel_id == SeqUpDown) ||
                         ((sel_id > SeqPushPull) && (sel_id <= SeqLast))) begin
               pend_sel = sel_id;
               spd_in   = cfg.default_speed;
               curv_in  = '0;
               dist_in  = '0;
            end
            pend_in = pend_sel;
            upd_p   = (cur_ff == pend_sel);
         end
      end

      if (poll_go) begin
         case (phase_ff)
            PH_IDLE, PH_WAIT: ;
            PH_MOVE: begin
               start_p = 1'b1;
            end
            PH_NEXT: begin
               if ((stg == ST_PREPARE) && (nxt >= {1'b0, tbl_rd_row.main_begin})) begin
                  stg = ST_MAIN;
               end
               if ((stg == ST_MAIN) && (nxt >= {1'b0, tbl_rd_row.final_begin})) begin
                  if (cur_ff != pend_ff) begin
                     nxt      = {1'b0, tbl_rd_row.final_begin};
                     row_val  = tbl_rd_row.final_begin;
                     from_row = 1'b1;
                     stg      = ST_FINALIZE;
                  end else if (tbl_rd_row.looped) begin
                     nxt      = {1'b0, tbl_rd_row.main_begin};
                     row_val  = tbl_rd_row.main_begin;
                     from_row = 1'b1;
                  end else begin
                     pend_in  = SeqNone;
                     end_main = 1'b1;
                  end
               end
               if ((stg == ST_FINALIZE) && (nxt >= {1'b0, tbl_rd_row.total})) begin
                  fin_done    = 1'b1;
                  standing_in = (cur_ff != SeqDown);
               end
               stage_in = stg;
               // The increment reaches the motion count at most; a restart index
               // from the table goes through the wrap table.
               if (from_row) begin
                  cnt_in = wrap_tbl[row_val];
               end else if (nxt == WrapAt) begin
                  cnt_in = '0;
               end else begin
                  cnt_in = nxt[CntW-1:0];
               end
            end
            PH_CHANGE: begin
               cur_in   = pend_ff;
               cnt_in   = '0;
               stage_in = ST_PREPARE;
               if (pend_ff == SeqNone) begin
                  last_in = item_ff.time_ms;
               end else begin
                  init_p = 1'b1;
               end
            end
            default: begin
               disabled_in = 1'b1;
            end
         endcase
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (poll_go) begin
         case (phase_ff)
            PH_IDLE: begin
               if (cur_ff != pend_ff) begin
                  phase_in = PH_CHANGE;
               end
            end
            PH_MOVE: phase_in = PH_WAIT;
            PH_WAIT: begin
               if (item_ff.motion_done) begin
                  phase_in = PH_NEXT;
               end
            end
            PH_NEXT: begin
               phase_in = (end_main || fin_done) ? PH_CHANGE : PH_MOVE;
            end
            PH_CHANGE: begin
               phase_in = (pend_ff == SeqNone) ? PH_IDLE : PH_MOVE;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_comb begin
      rsp_data_in.start_motion    = start_p;
      rsp_data_in.active_sequence = cur_in;
      rsp_data_in.motion_index    = CountW'(cnt_in);
      rsp_data_in.config_init     = init_p;
      rsp_data_in.config_update   = upd_p;
      rsp_data_in.out_speed       = $signed(spd_in);
      rsp_data_in.out_curvature   = $signed(curv_in);
      rsp_data_in.out_distance    = $signed(dist_in);
      rsp_data_in.body_up         = standing_in;
      rsp_data_in.fatal_error     = disabled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         phase_ff    <= PH_IDLE;
         stage_ff    <= ST_PREPARE;
         cnt_ff      <= '0;
         cur_ff      <= SeqDown;
         pend_ff     <= SeqDown;
         standing_ff <= 1'b0;
         last_ff     <= '0;
         spd_ff      <= '0;
         curv_ff     <= '0;
         dist_ff     <= '0;
         disabled_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (advance) begin
            phase_ff    <= phase_in;
            stage_ff    <= stage_in;
            cnt_ff      <= cnt_in;
            cur_ff      <= cur_in;
            pend_ff     <= pend_in;
            standing_ff <= standing_in;
            last_ff     <= last_in;
            spd_ff      <= spd_in;
            curv_ff     <= curv_in;
            dist_ff     <= dist_in;
            disabled_ff <= disabled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid           = rsp_vld_ff;
   assign rsp.start_motion    = rsp_data_ff.start_motion;
   assign rsp.active_sequence = rsp_data_ff.active_sequence;
   assign rsp.motion_index    = rsp_data_ff.motion_index;
   assign rsp.config_init     = rsp_data_ff.config_init;
   assign rsp.config_update   = rsp_data_ff.config_update;
   assign rsp.out_speed       = rsp_data_ff.out_speed;
   assign rsp.out_curvature   = rsp_data_ff.out_curvature;
   assign rsp.out_distance    = rsp_data_ff.out_distance;
   assign rsp.body_up         = rsp_data_ff.body_up;
   assign rsp.fatal_error     = rsp_data_ff.fatal_error;

   // A started motion always leaves the engine waiting for the executor.
   a_move_to_wait: assert property (@(posedge clock) disable iff (reset)
      (advance && poll_go && (phase_ff == PH_MOVE)) |=> (phase_ff == PH_WAIT))
      else $error("engine did not enter the wait phase after starting a motion");

   // The fatal flag is sticky.
   a_fatal_sticky: assert property (@(posedge clock) disable iff (reset)
      disabled_ff |=> disabled_ff)
      else $error("fatal flag cleared without reset");

   // The motion counter stays below the motion count.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntMax)
      else $error("motion counter beyond the motion count");

   // Only known sequences can become pending.
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      (pend_ff <= SeqLast) && (cur_ff <= SeqLast))
      else $error("pending or current sequence outside the known ids");

   // A new result appears only for an item that just left the input register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(advance))
      else $error("result raised without an item");

endmodule

### sv/motion_sequence_controller_top.sv
// Top level of the motion sequence controller.
`timescale 1ns / 1ps

// The controller takes one request per clock cycle while the result side is ready
// and returns exactly one result for each: the request is held in an input
// register, the engine updates its state, and the result waits in an output
// register while the next request is already taken in. Sustained rate is then
// one item per clock, set by the single state update per item in the engine. Poll
// requests step the engine through idle, start, wait for done, next motion and
// sequence change; select requests apply the up/down rules and set the motion
// parameters; load requests write one row of the sequence table. Table rows are
// not cleared by reset, and a sequence must have its row loaded before it runs.
// Configuration registers (default speed at 0x0, idle timeout at 0x4) must be
// written only while no request is in flight; the block does not enforce this.
module motion_sequence_controller_top #(
   parameter int unsigned NUM_SEQUENCES = msc_pkg::NumSequencesDefault,
   parameter int unsigned MAX_MOTIONS   = msc_pkg::MaxMotionsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   msc_req_if.sink                       req,
   msc_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [msc_pkg::CsrAddrW-1:0]  paddr,
   input  logic [msc_pkg::CsrDataW-1:0]  pwdata,
   output logic [msc_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready
);
   import msc_pkg::*;

   cfg_type           cfg;
   tbl_wr_type        tbl_wr;
   logic [SeqIdW-1:0] tbl_rd_idx;
   seq_row_type       tbl_rd_row;

   msc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   msc_table #(
      .NUM_SEQUENCES (NUM_SEQUENCES)
   ) u_table (
      .clock  (clock),
      .tbl_wr (tbl_wr),
      .rd_idx (tbl_rd_idx),
      .rd_row (tbl_rd_row)
   );

   msc_engine #(
      .NUM_SEQUENCES (NUM_SEQUENCES),
      .MAX_MOTIONS   (MAX_MOTIONS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .cfg        (cfg),
      .tbl_wr     (tbl_wr),
      .tbl_rd_idx (tbl_rd_idx),
      .tbl_rd_row (tbl_rd_row)
   );

endmodule

### dv/msc_checker.sv
// Checker that predicts every controller result and compares it with the result transfers.
`timescale 1ns / 1ps

module msc_checker (
   input  logic                         clock,
   input  logic                         reset,
   msc_req_if                           req,
   msc_rsp_if                           rsp,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic                         pready,
   input  logic [msc_pkg::CsrAddrW-1:0] paddr,
   input  logic [msc_pkg::CsrDataW-1:0] pwdata,
   output int unsigned                  fail_count,
   output int unsigned                  in_flight
);
   import msc_pkg::*;

   localparam int unsigned MaxPrinted = 40;

   rsp_item_type      motion_results_due [$];

   // Register copies, taken from the write transfers on the APB port.
   logic [ParamW-1:0] cfg_speed;
   logic [TimeW-1:0]  cfg_timeout;

   // Engine state of the predictor.
   seq_row_type       seq_rows [NumSequencesDefault];
   phase_type         eng_phase;
   stage_type         eng_stage;
   logic [CountW-1:0] motion_cnt;
   logic [SeqIdW-1:0] cur_seq;
   logic [SeqIdW-1:0] next_seq;
   logic              standing;
   logic              halted;
   logic [TimeW-1:0]  idle_since;
   logic [ParamW-1:0] speed_q;
   logic [ParamW-1:0] curv_q;
   logic [ParamW-1:0] dist_q;
   logic              touched;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= MaxPrinted)
         $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   function automatic void load_params(input logic [ParamW-1:0] spd,
                                       input logic [ParamW-1:0] curv,
                                       input logic [ParamW-1:0] distance);
      speed_q = spd;
      curv_q  = curv;
      dist_q  = distance;
   endfunction

   // Up/down gating: while down only up is accepted; while standing, down and
   // every sequence above it up to the last one are accepted.
   function automatic void apply_select(input logic [SeqIdW-1:0] id,
                                        input logic [ParamW-1:0] spd,
                                        input logic [ParamW-1:0] curv,
                                        input logic [ParamW-1:0] distance);
      if (int'(id) >= NumSequencesDefault) begin
         halted = 1'b1;
         return;
      end
      if (id == SeqNone) begin
         next_seq = SeqNone;
         return;
      end
      if (!standing) begin
         if (id == SeqUp) begin
            next_seq = id;
            load_params(cfg_speed, '0, '0);
         end
      end else if (id == SeqMove) begin
         next_seq = id;
         load_params(spd, curv, distance);
      end else if (id == SeqPushPull) begin
         next_seq = id;
         load_params(cfg_speed, PushPullCurv, PushPullDist);
      end else if (id == SeqDown || id == SeqUpDown ||
                   (id > SeqPushPull && id <= SeqLast)) begin
         next_seq = id;
         load_params(cfg_speed, '0, '0);
      end
      if (cur_seq == next_seq)
         touched = 1'b1;
   endfunction

   function automatic rsp_item_type predict_motion_result(input req_item_type it);
      rsp_item_type      res;
      seq_row_type       row;
      logic [CountW:0]   nxt;
      logic [TimeW-1:0]  idle_for;
      logic              started;
      logic              inited;
      started = 1'b0;
      inited  = 1'b0;
      touched = 1'b0;
      case (op_type'(it.opcode))
         OP_LOAD: begin
            if (int'(it.sequence_id) < NumSequencesDefault)
               seq_rows[it.sequence_id] = it.row;
         end
         OP_SELECT: begin
            apply_select(it.sequence_id, it.req_speed, it.req_curvature, it.req_distance);
         end
         OP_POLL: begin
            if (!halted) begin
               case (eng_phase)
                  PH_IDLE: begin
                     idle_for = it.time_ms - idle_since;
                     if (cur_seq != next_seq)
                        eng_phase = PH_CHANGE;
                     else if (idle_for > cfg_timeout)
                        apply_select(SeqDown, '0, '0, '0);
                  end
                  PH_MOVE: begin
                     started   = 1'b1;
                     eng_phase = PH_WAIT;
                  end
                  PH_WAIT: begin
                     if (it.motion_done)
                        eng_phase = PH_NEXT;
                  end
                  PH_NEXT: begin
                     row       = seq_rows[cur_seq];
                     nxt       = {1'b0, motion_cnt} + 1'b1;
                     eng_phase = PH_MOVE;
                     if (eng_stage == ST_PREPARE && nxt >= {1'b0, row.main_begin})
                        eng_stage = ST_MAIN;
                     if (eng_stage == ST_MAIN && nxt >= {1'b0, row.final_begin}) begin
                        if (cur_seq != next_seq) begin
                           nxt       = {1'b0, row.final_begin};
                           eng_stage = ST_FINALIZE;
                        end else if (row.looped) begin
                           nxt = {1'b0, row.main_begin};
                        end else begin
                           apply_select(SeqNone, '0, '0, '0);
                           eng_phase = PH_CHANGE;
                        end
                     end
                     if (eng_stage == ST_FINALIZE && nxt >= {1'b0, row.total}) begin
                        eng_phase = PH_CHANGE;
                        standing  = (cur_seq != SeqDown);
                     end
                     // The comparisons above use the unwrapped count; the stored
                     // index wraps at the motion limit of 256.
                     motion_cnt = nxt[CountW-1:0];
                  end
                  PH_CHANGE: begin
                     cur_seq    = next_seq;
                     motion_cnt = '0;
                     eng_stage  = ST_PREPARE;
                     eng_phase  = PH_MOVE;
                     if (cur_seq == SeqNone) begin
                        eng_phase  = PH_IDLE;
                        idle_since = it.time_ms;
                     end else begin
                        inited = 1'b1;
                     end
                  end
                  default: halted = 1'b1;
               endcase
            end
         end
         default: ;
      endcase
      res.start_motion    = started;
      res.active_sequence = cur_seq;
      res.motion_index    = motion_cnt;
      res.config_init     = inited;
      res.config_update   = touched;
      res.out_speed       = speed_q;
      res.out_curvature   = curv_q;
      res.out_distance    = dist_q;
      res.body_up         = standing;
      res.fatal_error     = halted;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      req_item_type seen;
      rsp_item_type want;
      if (reset) begin
         motion_results_due.delete();
         cfg_speed   = ResetSpeed;
         cfg_timeout = ResetTimeout;
         foreach (seq_rows[i])
            seq_rows[i] = '0;
         eng_phase  = PH_IDLE;
         eng_stage  = ST_PREPARE;
         motion_cnt = '0;
         cur_seq    = SeqDown;
         next_seq   = SeqDown;
         standing   = 1'b0;
         halted     = 1'b0;
         idle_since = '0;
         load_params('0, '0, '0);
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CsrAddrW-1:2])
               REG_DEFAULT_SPEED: cfg_speed   = pwdata[ParamW-1:0];
               REG_IDLE_TIMEOUT:  cfg_timeout = pwdata[TimeW-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            seen.opcode           = req.opcode;
            seen.sequence_id      = req.sequence_id;
            seen.req_speed        = req.req_speed;
            seen.req_curvature    = req.req_curvature;
            seen.req_distance     = req.req_distance;
            seen.motion_done      = req.motion_done;
            seen.time_ms          = req.time_ms;
            seen.row.main_begin   = req.row_main_begin;
            seen.row.final_begin  = req.row_final_begin;
            seen.row.total        = req.row_total;
            seen.row.looped       = req.row_looped;
            motion_results_due.push_back(predict_motion_result(seen));
         end
         if (rsp.valid && rsp.ready) begin
            if (motion_results_due.size() == 0) begin
               report_mismatch("result transfer with nothing expected",
                               rsp.active_sequence, '0);
            end else begin
               want = motion_results_due.pop_front();
               check_field("start_motion", rsp.start_motion, want.start_motion);
               check_field("active_sequence", rsp.active_sequence, want.active_sequence);
               check_field("motion_index", rsp.motion_index, want.motion_index);
               check_field("config_init", rsp.config_init, want.config_init);
               check_field("config_update", rsp.config_update, want.config_update);
               check_field("out_speed", rsp.out_speed, want.out_speed);
               check_field("out_curvature", rsp.out_curvature, want.out_curvature);
               check_field("out_distance", rsp.out_distance, want.out_distance);
               check_field("body_up", rsp.body_up, want.body_up);
               check_field("fatal_error", rsp.fatal_error, want.fatal_error);
            end
         end
      end
      in_flight <= $unsigned(motion_results_due.size());
   end

endmodule

### dv/tb_motion_sequence_controller_top.sv
// Testbench top: request and register stimulus for the controller, and the final verdict.
`timescale 1ns / 1ps

module tb_motion_sequence_controller_top;
   import msc_pkg::*;

   localparam int unsigned PhaseItems = 300;
   localparam int unsigned NumPhases  = 6;
   localparam int unsigned HoldCycles = 120;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [CsrDataW-1:0] pwdata;
   logic [CsrDataW-1:0] prdata;
   logic                pready;
   int unsigned         fail_count;
   int unsigned         in_flight;
   logic [TimeW-1:0]    now_ms;
   bit                  burst_mode;
   bit                  hold_done;
   bit                  req_calm;
   bit                  rsp_calm;

   msc_req_if req_bus ();
   msc_rsp_if rsp_bus ();

   motion_sequence_controller_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   msc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .in_flight  (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // A short sequence row: prepare, main and finalize parts of up to three motions.
   function automatic seq_row_type small_row();
      seq_row_type row;
      row.main_begin  = CountW'($urandom_range(0, 3));
      row.final_begin = row.main_begin + CountW'($urandom_range(0, 3));
      row.total       = row.final_begin + CountW'($urandom_range(0, 3));
      row.looped      = 1'($urandom_range(0, 1));
      return row;
   endfunction

   // Random content around a given operation; the time moves forward by small
   // steps and now and then jumps anywhere, wrapping included.
   function automatic req_item_type random_request(input op_type op,
                                                   input logic [SeqIdW-1:0] id);
      req_item_type it;
      if ($urandom_range(0, 19) == 0)
         now_ms = $urandom;
      else
         now_ms = now_ms + TimeW'($urandom_range(0, 40));
      it.opcode          = op;
      it.sequence_id     = id;
      it.req_speed       = ParamW'($urandom);
      it.req_curvature   = ParamW'($urandom);
      it.req_distance    = ParamW'($urandom);
      it.motion_done     = ($urandom_range(0, 2) != 0);
      it.time_ms         = now_ms;
      it.row.main_begin  = CountW'($urandom);
      it.row.final_begin = CountW'($urandom);
      it.row.total       = CountW'($urandom);
      it.row.looped      = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Mostly polls, so the engine gets through whole sequences; selections lean
   // toward none and up, which are what open the way to standing.
   function automatic req_item_type draw_request();
      req_item_type it;
      int unsigned  pick;
      int unsigned  k;
      pick = $urandom_range(0, 99);
      it = random_request(OP_POLL, SeqIdW'($urandom_range(0, 15)));
      if (pick >= 70 && pick < 90) begin
         it.opcode = OP_SELECT;
         k = $urandom_range(0, 9);
         if (k < 2)
            it.sequence_id = SeqNone;
         else if (k < 4)
            it.sequence_id = SeqUp;
         else if (k < 8)
            it.sequence_id = SeqIdW'($urandom_range(1, 10));
      end else if (pick >= 90 && pick < 97) begin
         it.opcode = OP_LOAD;
         if ($urandom_range(0, 19) != 0)
            it.row = small_row();
      end else if (pick >= 97) begin
         it.opcode = OP_NONE;
      end
      return it;
   endfunction

   task automatic send_request(input req_item_type it);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0)
         req_calm = !req_calm;
      gap = (burst_mode || req_calm) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.opcode          <= it.opcode;
      req_bus.sequence_id     <= it.sequence_id;
      req_bus.req_speed       <= it.req_speed;
      req_bus.req_curvature   <= it.req_curvature;
      req_bus.req_distance    <= it.req_distance;
      req_bus.motion_done     <= it.motion_done;
      req_bus.time_ms         <= it.time_ms;
      req_bus.row_main_begin  <= it.row.main_begin;
      req_bus.row_final_begin <= it.row.final_begin;
      req_bus.row_total       <= it.row.total;
      req_bus.row_looped      <= it.row.looped;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [CsrDataW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Waits until every result has come back.
   task automatic drain();
      do @(posedge clock); while (in_flight != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin : result_sink
      int unsigned gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rsp_calm = !rsp_calm;
         gap = (burst_mode || rsp_calm) ? 0 : $urandom_range(0, 11);
         // One long hold while requests keep coming, so the block backs up.
         if (burst_mode && !hold_done) begin
            gap       = HoldCycles;
            hold_done = 1'b1;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      req_item_type      it;
      logic [ParamW-1:0] spd;
      logic [TimeW-1:0]  tmo;
      reset                   <= 1'b1;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= '0;
      pwdata                  <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.opcode          <= OP_NONE;
      req_bus.sequence_id     <= '0;
      req_bus.req_speed       <= '0;
      req_bus.req_curvature   <= '0;
      req_bus.req_distance    <= '0;
      req_bus.motion_done     <= 1'b0;
      req_bus.time_ms         <= '0;
      req_bus.row_main_begin  <= '0;
      req_bus.row_final_begin <= '0;
      req_bus.row_total       <= '0;
      req_bus.row_looped      <= 1'b0;
      now_ms = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every row is loaded before anything can run. Rows 14 and 15, which can never
      // become active, carry the extreme values.
      for (int id = 0; id < NumSequencesDefault; id++) begin
         it = random_request(OP_LOAD, SeqIdW'(id));
         if (id == 15)
            it.row = '1;
         else if (id == 14)
            it.row = '0;
         else
            it.row = small_row();
         send_request(it);
      end
      // Unused opcode with every field at its top value.
      it = '1;
      send_request(it);
      // Poll at time zero with all fields low.
      it = '0;
      send_request(it);
      // Down is gated while the body is down.
      it = random_request(OP_SELECT, SeqDown);
      it.req_speed = 16'sh8000;
      send_request(it);
      it = random_request(OP_SELECT, SeqUp);
      it.req_speed     = 16'sh7fff;
      it.req_curvature = 16'sh8000;
      it.req_distance  = 16'sh7fff;
      send_request(it);
      it = random_request(OP_POLL, SeqNone);
      it.time_ms = '1;
      send_request(it);
      for (int n = 0; n < 4; n++) begin
         it = random_request(OP_POLL, SeqNone);
         it.motion_done = 1'b1;
         send_request(it);
      end
      it = random_request(OP_SELECT, SeqMove);
      send_request(it);
      req_bus.valid <= 1'b0;

      for (int ph = 0; ph < NumPhases; ph++) begin
         drain();
         case (ph)
            0: begin
               spd = '0;
               tmo = '0;
            end
            1: begin
               spd = '1;
               tmo = '1;
            end
            3: begin
               spd = ResetSpeed;
               tmo = ResetTimeout;
            end
            5: begin
               spd = 16'd1;
               tmo = 32'd1;
            end
            default: begin
               spd = ParamW'($urandom);
               tmo = TimeW'($urandom_range(20, 5000));
            end
         endcase
         csr_write(REG_DEFAULT_SPEED, CsrDataW'(spd));
         csr_write(REG_IDLE_TIMEOUT, CsrDataW'(tmo));
         burst_mode = (ph == 1);
         repeat (PhaseItems) send_request(draw_request());
         req_bus.valid <= 1'b0;
      end
      burst_mode = 1'b0;
      drain();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
sv/msc_pkg.sv
sv/msc_req_if.sv
sv/msc_rsp_if.sv
sv/msc_csr.sv
sv/msc_table.sv
sv/msc_engine.sv
sv/motion_sequence_controller_top.sv
dv/msc_checker.sv
dv/tb_motion_sequence_controller_top.sv
